/* rtl/core/intensity_to_rgb_colormap_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the intensity to RGB color map
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTENSITY_TO_RGB_COLORMAP_MACROS_SVH
`define INTENSITY_TO_RGB_COLORMAP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ITRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked at every clock edge out of reset.
`define ITRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/itrc_pkg.sv */
// ----------------------------------------------------------------------------
// itrc_pkg
// Types, codes, constants and palettes shared by the color map modules.
// ----------------------------------------------------------------------------
package itrc_pkg;

  typedef enum logic [1:0] {
    MODE_GREY  = 2'd0,
    MODE_HEAT4 = 2'd1,
    MODE_HEAT6 = 2'd2,
    MODE_SCALE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MAP_MODE   = 3'd0,
    REG_MIN        = 3'd1,
    REG_MAX        = 3'd2,
    REG_RED_GAIN   = 3'd3,
    REG_GREEN_GAIN = 3'd4,
    REG_BLUE_GAIN  = 3'd5
  } reg_idx_e;

  // Classification made by the front end for each sample.
  typedef struct packed {
    logic bad;   // maximum does not exceed minimum
    logic zero;  // normalized value is zero
    logic sat;   // normalized value saturates
  } cls_t;

  localparam int REG_IDX_BITS = 3;
  localparam int GAIN_BITS    = 8;
  localparam int V_BITS       = 13;           // normalized value, Q1.12
  localparam logic [V_BITS-1:0] V_SAT = 13'd8191;
  localparam int PRE_BITS     = V_BITS + GAIN_BITS;
  localparam int ROUND_Q13    = 4096;
  localparam int SCALE_BIAS   = 522240;       // half of 255 * 4096
  localparam int A_BITS       = 24;
  localparam int RECIP_BITS   = 25;
  localparam int RECIP_SHIFT  = 32;
  // ceil(2^32 / 255); exact quotient for dividends below 2^24.
  localparam logic [RECIP_BITS-1:0] RECIP_255 = 25'd16843010;
  localparam int QUEUE_DEPTH  = 4;

  typedef logic [2:0][1:0] lvl_t;  // per channel level in halves, red at index 0

  // Blue, green, yellow, red.
  function automatic lvl_t pal4(input logic [1:0] idx);
    lvl_t l;
    case (idx)
      2'd0:    l = {2'd2, 2'd0, 2'd0};
      2'd1:    l = {2'd0, 2'd2, 2'd0};
      2'd2:    l = {2'd0, 2'd2, 2'd2};
      default: l = {2'd0, 2'd0, 2'd2};
    endcase
    return l;
  endfunction

  // Black, dark blue, violet, red, yellow, white.
  function automatic lvl_t pal6(input logic [2:0] idx);
    lvl_t l;
    case (idx)
      3'd0:    l = {2'd0, 2'd0, 2'd0};
      3'd1:    l = {2'd1, 2'd0, 2'd0};
      3'd2:    l = {2'd1, 2'd0, 2'd1};
      3'd3:    l = {2'd0, 2'd0, 2'd2};
      3'd4:    l = {2'd0, 2'd2, 2'd2};
      3'd5:    l = {2'd2, 2'd2, 2'd2};
      default: l = {2'd0, 2'd0, 2'd0};
    endcase
    return l;
  endfunction

endpackage

/* rtl/core/intensity_to_rgb_colormap.sv */
// ----------------------------------------------------------------------------
// intensity_to_rgb_colormap
// A sample passes the front register, the queue, the one-bit-per-stage pipelined
// divider that normalizes it, then the mapping stages C1, C2, C3 and the output.
// Throughput: one sample per cycle unless the output stalls, which the 4-entry queue absorbs.
// Reset: registers return to greyscale, range 0..1 and full gains; all
// pipeline and queue valid state is cleared at once, no clearing pass.
// ----------------------------------------------------------------------------
module intensity_to_rgb_colormap #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [itrc_pkg::REG_IDX_BITS-1:0]         cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]                    cfg_data_i,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,  // intensity
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((3 * COLOR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata, // blue, green, red from the top
  output logic                                      m_axis_tuser   // bad_range
);

  localparam int ODW = ((3 * COLOR_BITS + 7) / 8) * 8;
  localparam int QW  = (SAMPLE_BITS + 1) + SAMPLE_BITS + $bits(itrc_pkg::cls_t);

  itrc_pkg::mode_e                            mode_q;
  logic signed [SAMPLE_BITS-1:0]              lo_q, hi_q;
  logic [2:0][itrc_pkg::GAIN_BITS-1:0]        gains_q;

  logic                   push, pop, full, empty;
  logic [SAMPLE_BITS:0]   f_diff, b_diff;
  logic [SAMPLE_BITS-1:0] f_range, b_range;
  itrc_pkg::cls_t         f_cls, b_cls;
  logic [QW-1:0]          q_rdata;
  logic [2:0][COLOR_BITS-1:0] rgb;
  logic                   bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= itrc_pkg::MODE_GREY;
      lo_q    <= '0;
      hi_q    <= SAMPLE_BITS'(1);
      gains_q <= {3{8'd255}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        itrc_pkg::REG_MAP_MODE:   mode_q     <= itrc_pkg::mode_e'(cfg_data_i[1:0]);
        itrc_pkg::REG_MIN:        lo_q       <= cfg_data_i;
        itrc_pkg::REG_MAX:        hi_q       <= cfg_data_i;
        itrc_pkg::REG_RED_GAIN:   gains_q[0] <= cfg_data_i[7:0];
        itrc_pkg::REG_GREEN_GAIN: gains_q[1] <= cfg_data_i[7:0];
        itrc_pkg::REG_BLUE_GAIN:  gains_q[2] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  itrc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .full_i    (full),
    .push_o    (push),
    .diff_o    (f_diff),
    .range_o   (f_range),
    .cls_o     (f_cls)
  );

  itrc_fifo #(
    .WIDTH(QW),
    .DEPTH(itrc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_diff, f_range, f_cls}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_diff, b_range, b_cls} = q_rdata;

  itrc_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .gains_i     (gains_q),
    .in_valid_i  (!empty),
    .pop_o       (pop),
    .in_diff_i   (b_diff),
    .in_range_i  (b_range),
    .in_cls_i    (b_cls),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rgb_o   (rgb),
    .out_bad_o   (bad)
  );

  assign m_axis_tdata = ODW'({rgb[2], rgb[1], rgb[0]});
  assign m_axis_tuser = bad;

endmodule

/* rtl/core/itrc_front.sv */
// ----------------------------------------------------------------------------
// itrc_front
// Accepts samples, offsets them by the minimum and classifies the range.
// ----------------------------------------------------------------------------
module itrc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] lo_i,
  input  logic signed [SAMPLE_BITS-1:0] hi_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic        [SAMPLE_BITS:0]   diff_o,
  output logic        [SAMPLE_BITS-1:0] range_o,
  output itrc_pkg::cls_t               cls_o
);

  logic                          vld_q;
  logic                          accept;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS:0]   rng;
  itrc_pkg::cls_t                cls_d;
  logic        [SAMPLE_BITS:0]   diff_q;
  logic        [SAMPLE_BITS-1:0] range_q;
  itrc_pkg::cls_t                cls_q;

  assign s_ready_o = !vld_q || !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = vld_q && !full_i;

  always_comb begin
    diff      = $signed({sample_i[SAMPLE_BITS-1], sample_i}) - $signed({lo_i[SAMPLE_BITS-1], lo_i});
    rng       = $signed({hi_i[SAMPLE_BITS-1], hi_i}) - $signed({lo_i[SAMPLE_BITS-1], lo_i});
    cls_d.bad = (hi_i <= lo_i);
    cls_d.zero = cls_d.bad || diff[SAMPLE_BITS] || (diff == '0);
    // At twice the range or more the quotient no longer fits in 13 bits.
    cls_d.sat = !cls_d.zero &&
                ($signed({diff[SAMPLE_BITS], diff}) >= $signed({rng, 1'b0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q  <= diff;
      range_q <= rng[SAMPLE_BITS-1:0];
      cls_q   <= cls_d;
    end
  end

  assign diff_o  = diff_q;
  assign range_o = range_q;
  assign cls_o   = cls_q;

endmodule

/* rtl/core/itrc_fifo.sv */
// ----------------------------------------------------------------------------
// itrc_fifo
// Short queue between the classifying front end and the mapping back end.
// ----------------------------------------------------------------------------
`include "intensity_to_rgb_colormap_macros.svh"

module itrc_fifo #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ITRC_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `ITRC_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "request pushed into a full queue")
  `ITRC_ASSERT_IMPL(a_no_underflow, pop_i, !empty_o, "request popped from an empty queue")

endmodule

/* rtl/core/itrc_back.sv */
// ----------------------------------------------------------------------------
// itrc_back
// Pipelined restoring divider followed by the color mapping stages.
// ----------------------------------------------------------------------------
`include "intensity_to_rgb_colormap_macros.svh"

module itrc_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int COLOR_BITS  = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  itrc_pkg::mode_e                               mode_i,
  input  logic [2:0][itrc_pkg::GAIN_BITS-1:0]           gains_i,
  input  logic                                          in_valid_i,
  output logic                                          pop_o,
  input  logic [SAMPLE_BITS:0]                          in_diff_i,
  input  logic [SAMPLE_BITS-1:0]                        in_range_i,
  input  itrc_pkg::cls_t                                in_cls_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [2:0][COLOR_BITS-1:0]                    out_rgb_o,
  output logic                                          out_bad_o
);

  localparam int RW   = SAMPLE_BITS + 1;
  localparam int NQ   = itrc_pkg::V_BITS;
  localparam int PREW = itrc_pkg::PRE_BITS;
  localparam int PW   = PREW + COLOR_BITS;
  localparam int LW   = PW - 12;              // rounded linear channel
  localparam int AW   = PW - 11;              // color scale dividend
  localparam int QW   = itrc_pkg::A_BITS + itrc_pkg::RECIP_BITS - itrc_pkg::RECIP_SHIFT;
  localparam int MW   = itrc_pkg::A_BITS + itrc_pkg::RECIP_BITS;
  localparam logic [COLOR_BITS-1:0] CMAX  = '1;
  localparam logic [AW-1:0]         A_LIM = AW'(255 * (2 ** COLOR_BITS));

  logic en;

  // Divider stages: stage k resolves quotient bit NQ-1-k.
  logic [NQ-1:0]          dv_vld_q;
  logic [RW-1:0]          rem_q [NQ];
  logic [SAMPLE_BITS-1:0] dvs_q [NQ];
  logic [NQ-1:0]          quo_q [NQ];
  itrc_pkg::cls_t         cls_q [NQ];
  logic [RW-1:0]          rem_in [NQ];
  logic [SAMPLE_BITS-1:0] dvs_in [NQ];
  logic [NQ-1:0]          quo_in [NQ];
  itrc_pkg::cls_t         cls_in [NQ];
  logic [RW-1:0]          sub [NQ];
  logic [NQ-1:0]          ge;
  logic [RW-1:0]          rem_d [NQ];
  logic [NQ-1:0]          quo_d [NQ];

  // Mapping stages.
  logic [NQ-1:0]               v;
  logic                        big, six;
  logic [14:0]                 t;
  logic [11:0]                 frac;
  logic [2:0]                  seg, last, i1, i2;
  itrc_pkg::lvl_t              lv1, lv2;
  logic [2:0][13:0]            c13;
  logic [2:0][PREW-1:0]        pre_d, pre_q;
  logic                        c1_vld_q, c1_bad_q;
  logic [2:0][PW-1:0]          prod_q;
  logic                        c2_vld_q, c2_bad_q;
  logic [2:0][PW:0]            sum_lin, sum_sc;
  logic [2:0][LW-1:0]          lin_o;
  logic [2:0][AW-1:0]          a_full;
  logic [2:0][COLOR_BITS-1:0]  lin_d, lin_q;
  logic [2:0][itrc_pkg::A_BITS-1:0] a_d, a_q;
  logic [2:0]                  asat_d, asat_q;
  logic                        c3_vld_q, c3_bad_q;
  logic [2:0][MW-1:0]          mprod;
  logic [2:0][QW-1:0]          q;
  logic [2:0][COLOR_BITS-1:0]  rgb_d, rgb_q;
  logic                        out_vld_q, out_bad_q;

  // The whole pipeline holds while a finished pixel waits at the output.
  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && in_valid_i;

  always_comb begin
    rem_in[0] = in_diff_i;
    dvs_in[0] = in_range_i;
    quo_in[0] = '0;
    cls_in[0] = in_cls_i;
    for (int k = 1; k < NQ; k++) begin
      rem_in[k] = rem_q[k-1];
      dvs_in[k] = dvs_q[k-1];
      quo_in[k] = quo_q[k-1];
      cls_in[k] = cls_q[k-1];
    end
    for (int k = 0; k < NQ; k++) begin
      ge[k]    = (rem_in[k] >= {1'b0, dvs_in[k]});
      sub[k]   = ge[k] ? (rem_in[k] - {1'b0, dvs_in[k]}) : rem_in[k];
      rem_d[k] = {sub[k][RW-2:0], 1'b0};
      quo_d[k] = {quo_in[k][NQ-2:0], ge[k]};
    end
  end

  // Stage C1: grey value, palette interpolation or gain product, per channel.
  always_comb begin
    if (cls_q[NQ-1].zero) begin
      v = '0;
    end else if (cls_q[NQ-1].sat) begin
      v = itrc_pkg::V_SAT;
    end else begin
      v = quo_q[NQ-1];
    end
    big  = v[NQ-1];
    six  = (mode_i == itrc_pkg::MODE_HEAT6);
    t    = six ? (15'({v[11:0], 2'b00}) + 15'(v[11:0]))
               : (15'({v[11:0], 1'b0}) + 15'(v[11:0]));
    seg  = t[14:12];
    frac = big ? 12'd0 : t[11:0];
    last = six ? 3'd5 : 3'd3;
    i1   = big ? last : seg;
    i2   = big ? last : seg + 3'd1;
    lv1  = six ? itrc_pkg::pal6(i1) : itrc_pkg::pal4(i1[1:0]);
    lv2  = six ? itrc_pkg::pal6(i2) : itrc_pkg::pal4(i2[1:0]);
    for (int ch = 0; ch < 3; ch++) begin
      c13[ch] = 14'(16'(lv1[ch]) * 16'(13'd4096 - 13'(frac)) + 16'(lv2[ch]) * 16'(frac));
      case (mode_i)
        itrc_pkg::MODE_GREY:  pre_d[ch] = PREW'({v, 1'b0});
        itrc_pkg::MODE_HEAT4,
        itrc_pkg::MODE_HEAT6: pre_d[ch] = PREW'(c13[ch]);
        itrc_pkg::MODE_SCALE: pre_d[ch] = PREW'(gains_i[ch]) * PREW'(v);
        default:              pre_d[ch] = PREW'({v, 1'b0});
      endcase
    end
  end

  // Stage C3: rounding, and the biased color scale dividend divided by 4096.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_lin[ch] = (PW + 1)'(prod_q[ch]) + (PW + 1)'(itrc_pkg::ROUND_Q13);
      lin_o[ch]   = sum_lin[ch][PW:13];
      lin_d[ch]   = (lin_o[ch] > LW'(CMAX)) ? CMAX : lin_o[ch][COLOR_BITS-1:0];
      sum_sc[ch]  = (PW + 1)'(prod_q[ch]) + (PW + 1)'(itrc_pkg::SCALE_BIAS);
      a_full[ch]  = sum_sc[ch][PW:12];
      asat_d[ch]  = (a_full[ch] >= A_LIM);
      a_d[ch]     = itrc_pkg::A_BITS'(a_full[ch]);
    end
  end

  // Output stage: in scale mode divide by 255 through the reciprocal, else pass the linear channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mprod[ch] = MW'(a_q[ch]) * MW'(itrc_pkg::RECIP_255);
      q[ch]     = mprod[ch][MW-1:itrc_pkg::RECIP_SHIFT];
      if (mode_i == itrc_pkg::MODE_SCALE) begin
        rgb_d[ch] = (asat_q[ch] || (q[ch] > QW'(CMAX))) ? CMAX : q[ch][COLOR_BITS-1:0];
      end else begin
        rgb_d[ch] = lin_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q  <= '0;
      c1_vld_q  <= 1'b0;
      c2_vld_q  <= 1'b0;
      c3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      dv_vld_q  <= {dv_vld_q[NQ-2:0], pop_o};
      c1_vld_q  <= dv_vld_q[NQ-1];
      c2_vld_q  <= c1_vld_q;
      c3_vld_q  <= c2_vld_q;
      out_vld_q <= c3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NQ; k++) begin
        rem_q[k] <= rem_d[k];
        dvs_q[k] <= dvs_in[k];
        quo_q[k] <= quo_d[k];
        cls_q[k] <= cls_in[k];
      end
      pre_q    <= pre_d;
      c1_bad_q <= cls_q[NQ-1].bad;
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= PW'(pre_q[ch]) * PW'(CMAX);
      end
      c2_bad_q  <= c1_bad_q;
      lin_q     <= lin_d;
      a_q       <= a_d;
      asat_q    <= asat_d;
      c3_bad_q  <= c2_bad_q;
      rgb_q     <= rgb_d;
      out_bad_q <= c3_bad_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rgb_o   = rgb_q;
  assign out_bad_o   = out_bad_q;

  `ITRC_ASSERT_IMPL(a_out_from_pipe, $rose(out_vld_q), $past(c3_vld_q), "pixel appeared without a request in the last stage")

endmodule
